### src/tvkt_pkg.sv
// ----------------------------------------------------------------------------
// Two-value key table package
// Shared types, codes and defaults for the key table core and its parts.
// ----------------------------------------------------------------------------
package tvkt_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CAP_W      = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   typedef enum logic {
      FUNC_ADD    = 1'b0,
      FUNC_REMOVE = 1'b1
   } func_type;

   typedef enum logic {
      REG_CAPACITY = 1'b0,
      REG_NULL     = 1'b1
   } csr_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FETCH,
      ST_REREAD,
      ST_COMMIT,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic               func;
      logic signed [31:0] key;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic               accepted;
      logic        [1:0]  found_count;
      logic signed [31:0] first_value;
      logic signed [31:0] second_value;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] key;
      logic signed [31:0] value;
   } entry_type;

endpackage

### src/tvkt_store.sv
// ----------------------------------------------------------------------------
// Key table entry store
// Single-port-read, single-port-write memory of key/value entries with a
// registered read.
// ----------------------------------------------------------------------------
module tvkt_store import tvkt_pkg::*; #(
   parameter int DEPTH  = DEPTH_DEFAULT,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic [ADDR_W-1:0] rd_addr,
   output entry_type         rd_entry,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  entry_type         wr_entry
);

   entry_type mem [DEPTH];
   entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      rd_entry_ff <= mem[rd_addr];
   end

   assign rd_entry = rd_entry_ff;

endmodule

### src/tvkt_seq.sv
// ----------------------------------------------------------------------------
// Key table sequencer
// Walks the stored entries one per cycle, save while a remove refills a slot,
// with a shared key comparator, moves the last entry into a freed slot,
// appends on add, and holds the result in an output register.
// ----------------------------------------------------------------------------
module tvkt_seq import tvkt_pkg::*; #(
   parameter int DEPTH  = DEPTH_DEFAULT,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp_data,
   input  logic [CAP_W-1:0]   capacity,
   input  logic signed [31:0] null_value,
   output logic [ADDR_W-1:0]  rd_addr,
   input  entry_type          rd_entry,
   output logic               wr_en,
   output logic [ADDR_W-1:0]  wr_addr,
   output entry_type          wr_entry
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   state_type          state_ff, state_in;
   logic               func_ff, func_in;
   logic signed [31:0] key_ff, key_in;
   logic signed [31:0] value_ff, value_in;
   logic [ADDR_W-1:0]  idx_ff, idx_in;
   logic [1:0]         hits_ff, hits_in;
   logic signed [31:0] first_ff, first_in;
   logic signed [31:0] second_ff, second_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               accepted_ff, accepted_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic [ADDR_W-1:0]  last_addr;
   logic [CNT_W-1:0]   idx_next;
   logic               key_match;
   logic               room;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      key_ff      <= key_in;
      value_ff    <= value_in;
      idx_ff      <= idx_in;
      hits_ff     <= hits_in;
      first_ff    <= first_in;
      second_ff   <= second_in;
      accepted_ff <= accepted_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign last_addr = ADDR_W'(count_ff - 1'b1);
   assign idx_next  = CNT_W'(idx_ff) + 1'b1;
   assign key_match = (rd_entry.key == key_ff);
   assign room      = (CMP_W'(count_ff) < CMP_W'(capacity)) &&
                      (count_ff < CNT_W'(DEPTH));

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      key_in       = key_ff;
      value_in     = value_ff;
      idx_in       = idx_ff;
      hits_in      = hits_ff;
      first_in     = first_ff;
      second_in    = second_ff;
      count_in     = count_ff;
      accepted_in  = accepted_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      rd_addr      = idx_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_entry     = rd_entry;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            rd_addr   = '0;
            if (req_valid) begin
               func_in  = req_data.func;
               key_in   = req_data.key;
               value_in = req_data.value;
               idx_in   = '0;
               hits_in  = '0;
               state_in = (count_ff == '0) ? ST_COMMIT : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (key_match && (func_ff == FUNC_REMOVE)) begin
               if (hits_ff == 2'd0) begin
                  first_in = rd_entry.value;
               end else begin
                  second_in = rd_entry.value;
               end
               hits_in  = hits_ff + 2'd1;
               rd_addr  = last_addr;
               state_in = ST_FETCH;
            end else if (key_match && (hits_ff == 2'd1)) begin
               hits_in  = 2'd2;
               state_in = ST_COMMIT;
            end else begin
               hits_in = hits_ff + {1'b0, key_match};
               if (idx_next == count_ff) begin
                  state_in = ST_COMMIT;
               end else begin
                  idx_in  = ADDR_W'(idx_next);
                  rd_addr = ADDR_W'(idx_next);
               end
            end
         end
         ST_FETCH: begin
            wr_en    = 1'b1;
            count_in = count_ff - 1'b1;
            if ((hits_ff == 2'd2) || (CNT_W'(idx_ff) >= count_ff - 1'b1)) begin
               state_in = ST_COMMIT;
            end else begin
               state_in = ST_REREAD;
            end
         end
         ST_REREAD: begin
            state_in = ST_SCAN;
         end
         ST_COMMIT: begin
            if (func_ff == FUNC_ADD) begin
               if ((hits_ff != 2'd2) && room) begin
                  wr_en          = 1'b1;
                  wr_addr        = ADDR_W'(count_ff);
                  wr_entry.key   = key_ff;
                  wr_entry.value = value_ff;
                  count_in       = count_ff + 1'b1;
                  accepted_in    = 1'b1;
               end else begin
                  accepted_in = 1'b0;
               end
            end else begin
               accepted_in = (hits_ff != 2'd0);
            end
            state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in.accepted     = accepted_ff;
               rsp_data_in.found_count  = (func_ff == FUNC_REMOVE) ? hits_ff : 2'd0;
               rsp_data_in.first_value  = ((func_ff == FUNC_REMOVE) && (hits_ff != 2'd0))
                                          ? first_ff : null_value;
               rsp_data_in.second_value = ((func_ff == FUNC_REMOVE) && (hits_ff == 2'd2))
                                          ? second_ff : null_value;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### src/two_value_key_table_core.sv
// ----------------------------------------------------------------------------
// Two-value key table core
// Compact table of key/value pairs holding at most two values per key, with
// add and remove-key operations and a register port for capacity and the
// null value.
//
//   Channel   Ports                      Transfer when
//   request   req_valid/ready/data       req_valid and req_ready high
//   response  rsp_valid/ready/data       rsp_valid and rsp_ready high
//   config    psel/penable/pwrite/...    psel, penable, pwrite, pready high
//
// One item at a time. The comparator reads one stored entry per cycle from
// the entry memory, except while a remove moves the last entry into a freed
// slot and rereads that slot. The response waits in an output register, so
// the next request is taken while it is pending.
// Synchronous reset empties the table; no clearing pass is needed.
// ----------------------------------------------------------------------------
module two_value_key_table_core import tvkt_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [CAP_W-1:0]   capacity_ff, capacity_in;
   logic signed [31:0] null_ff, null_in;
   logic               csr_write;
   csr_reg_type        csr_index;

   logic [ADDR_W-1:0]  rd_addr;
   entry_type          rd_entry;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   entry_type          wr_entry;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = csr_reg_type'(paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
         null_ff     <= '0;
      end else begin
         capacity_ff <= capacity_in;
         null_ff     <= null_in;
      end
   end

   always_comb begin
      capacity_in = capacity_ff;
      null_in     = null_ff;
      prdata      = '0;
      case (csr_index)
         REG_CAPACITY: begin
            prdata = CSR_DATA_W'(capacity_ff);
            if (csr_write) begin
               capacity_in = pwdata[CAP_W-1:0];
            end
         end
         REG_NULL: begin
            prdata = null_ff;
            if (csr_write) begin
               null_in = pwdata;
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   tvkt_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock    (clock),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_entry (wr_entry)
   );

   tvkt_seq #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .capacity   (capacity_ff),
      .null_value (null_ff),
      .rd_addr    (rd_addr),
      .rd_entry   (rd_entry),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_entry   (wr_entry)
   );

endmodule

### src/tvkt_checker.sv
// ----------------------------------------------------------------------------
// Two-value key table port checker
// Watches the core's ports and flags responses and handshakes that cannot
// come from a correct table.
// ----------------------------------------------------------------------------
module tvkt_port_assertions import tvkt_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data,
   input logic    pready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("Response changed or dropped before its transfer.");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("Request taken while the previous one is still in work.");

   a_found_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.found_count != 2'd3) &&
                    ((rsp_data.found_count == 2'd0) || rsp_data.accepted))
      else $error("Found count out of range or not reflected in accepted.");

   a_none_found_null: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.found_count == 2'd0) |->
         rsp_data.first_value == rsp_data.second_value)
      else $error("Missing values differ although both must be null.");

   a_pready: assert property (@(posedge clock) disable iff (reset) pready)
      else $error("Register port inserted a wait state.");

endmodule

bind two_value_key_table_core tvkt_port_assertions u_tvkt_port_assertions (.*);
